// File: hdl/uars_pkg.sv
// Package with the shared types, constants and fixed-point helpers of the upwind stage core.
`default_nettype none

package uars_pkg;

    localparam int CELL_INDEX_W = 10;
    localparam int VALUE_W      = 32;
    localparam int TIME_W       = 48;
    localparam int WEIGHT_W     = 25;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 48;

    localparam logic [WEIGHT_W-1:0] Q24_ONE  = 25'h100_0000;
    localparam logic [23:0]         Q24_HALF = 24'h80_0000;

    localparam logic [CFG_ADDR_W-1:0] CFG_VELOCITY     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_RATIO   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLEND_WEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_NOW     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_TIME    = 3'd5;

    localparam logic signed [31:0] VELOCITY_RESET = 32'sd16777216;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TB_HI,
        ST_TB_LO,
        ST_TS_HI,
        ST_TS_LO,
        ST_TACC_HI,
        ST_TACC_LO,
        ST_DIFF,
        ST_LD_BASE,
        ST_FLUX,
        ST_ACC_BASE,
        ST_UPDATE,
        ST_WAIT,
        ST_BLEND
    } t_state;

    // Round half up of a Q24-scaled product: floor((x + 2^23) / 2^24).
    function automatic logic signed [41:0] rnd_q24(input logic signed [65:0] x);
        logic signed [65:0] t;
        t = x + $signed({42'd0, Q24_HALF});
        return $signed(t[65:24]);
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/upwind_advection_rk_stage_core.sv
// Top level of the streaming first-order upwind advection stage on a periodic grid.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_cell_value, i_base_value, i_last_cell
//   result    out        o_out_valid / i_out_stall o_cell_index, o_new_value, o_new_time,
//                                                  o_last_result
//   config    in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// An input beat that produces no result (the first cell of a longer grid) is only stored
// and leaves the sequencer idle. A beat with one or two results is computed on the single
// 33 x 33 multiplier: four products for the stage time, then four per result.
// A stalled result holds the sequencer in its last step until the output register frees.
// Reset is synchronous and active low; it restores the register defaults and clears the
// grid position, the held neighbour cells and the output valid flag.
`default_nettype none

module upwind_advection_rk_stage_core #(
    parameter int MAX_CELLS = 1024
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [uars_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [uars_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input cell channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  signed [uars_pkg::VALUE_W-1:0]  i_cell_value,
    input  wire  signed [uars_pkg::VALUE_W-1:0]  i_base_value,
    input  wire                                  i_last_cell,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [uars_pkg::CELL_INDEX_W-1:0]    o_cell_index,
    output logic signed [uars_pkg::VALUE_W-1:0]  o_new_value,
    output logic [uars_pkg::TIME_W-1:0]          o_new_time,
    output logic                                 o_last_result
);
    import uars_pkg::*;

    // Width of the grid position counter; it never goes beyond MAX_CELLS - 1.
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_CELLS - 1);

    // Configuration registers.
    logic signed [31:0]       r_vel;
    logic [31:0]              r_ratio;
    logic [WEIGHT_W-1:0]      r_bw;
    logic [TIME_W-1:0]        r_tstep;
    logic [TIME_W-1:0]        r_tnow;
    logic [TIME_W-1:0]        r_tbase;

    // Sequencer and grid state.
    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_cnt;
    logic signed [31:0]       r_prev_v;
    logic signed [31:0]       r_prev_b;
    logic signed [31:0]       r_first_v;
    logic signed [31:0]       r_first_b;

    // Current beat.
    logic signed [31:0]       r_u;
    logic signed [31:0]       r_b;
    logic [CW-1:0]            r_k;
    logic                     r_two;
    logic                     r_job;

    // Shared multiplier with registered operands and product.
    logic signed [32:0]       r_ma;
    logic signed [32:0]       r_mb;
    logic signed [65:0]       r_prod;

    // Accumulators and the blended time.
    logic [TIME_W-1:0]        r_tsum;
    logic [73:0]              r_tacc;
    logic [TIME_W-1:0]        r_time;
    logic signed [57:0]       r_acc;

    // Output register.
    logic                     r_out_valid;
    logic [CELL_INDEX_W-1:0]  r_o_idx;
    logic signed [31:0]       r_o_val;
    logic [TIME_W-1:0]        r_o_time;
    logic                     r_o_last;

    // Combinational helpers.
    logic                     w_accept;
    logic                     w_last_eff;
    logic                     w_no_job;
    logic                     w_oload;
    logic                     w_finish;
    logic                     w_vpos;
    logic [WEIGHT_W-1:0]      w_a;
    logic [WEIGHT_W-1:0]      w_wb;
    logic [TIME_W:0]          w_tsum_full;
    logic [73:0]              w_tround;
    logic signed [31:0]       w_c;
    logic signed [31:0]       w_n;
    logic signed [31:0]       w_base;
    logic [CW-1:0]            w_idx;
    logic                     w_rlast;
    logic signed [32:0]       w_d;
    logic signed [41:0]       w_fd_r;
    logic signed [31:0]       w_fd;
    logic signed [41:0]       w_dl;
    logic signed [31:0]       w_nv;
    logic signed [58:0]       w_vsum;
    logic signed [41:0]       w_vr;
    logic signed [31:0]       w_val;

    // The weight saturates at one; the base side gets its complement.
    assign w_a  = (r_bw > Q24_ONE) ? Q24_ONE : r_bw;
    assign w_wb = Q24_ONE - w_a;
    assign w_vpos = (r_vel > 32'sd0);

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_last_eff = i_last_cell || (r_cnt == LAST_POS);
    // The first cell of a grid longer than one only gets stored.
    assign w_no_job   = (r_cnt == '0) && !w_last_eff;

    assign w_tsum_full = {1'b0, r_tnow} + {1'b0, r_tstep};
    assign w_tround    = r_tacc + {50'd0, Q24_HALF};

    // Neighbour selection. With positive velocity the arriving cell is finished against
    // its left neighbour, and at the end cell zero against the last cell. Otherwise the
    // previous cell is finished against the arriving one, and the last against cell zero.
    always_comb begin
        w_c     = r_u;
        w_n     = r_u;
        w_base  = r_b;
        w_idx   = '0;
        w_rlast = 1'b1;
        priority if (r_k == '0) begin
            w_c     = r_u;
            w_n     = r_u;
            w_base  = r_b;
            w_idx   = '0;
            w_rlast = 1'b1;
        end else if (w_vpos) begin
            if (!r_job) begin
                w_c     = r_u;
                w_n     = r_prev_v;
                w_base  = r_b;
                w_idx   = r_k;
                w_rlast = 1'b0;
            end else begin
                w_c     = r_first_v;
                w_n     = r_u;
                w_base  = r_first_b;
                w_idx   = '0;
                w_rlast = 1'b1;
            end
        end else begin
            if (!r_job) begin
                w_c     = r_prev_v;
                w_n     = r_u;
                w_base  = r_prev_b;
                w_idx   = CW'(r_k - 1'b1);
                w_rlast = 1'b0;
            end else begin
                w_c     = r_u;
                w_n     = r_first_v;
                w_base  = r_b;
                w_idx   = r_k;
                w_rlast = 1'b1;
            end
        end
    end

    // Upwind difference, oriented by the sign of the velocity.
    assign w_d = w_vpos ? ({w_c[31], w_c} - {w_n[31], w_n})
                        : ({w_n[31], w_n} - {w_c[31], w_c});

    assign w_fd_r = rnd_q24(r_prod);
    assign w_fd   = sat32({{22{w_fd_r[41]}}, w_fd_r});
    assign w_dl   = rnd_q24(r_prod);
    assign w_nv   = sat32({{32{w_c[31]}}, w_c} - {{22{w_dl[41]}}, w_dl});

    assign w_vsum = {r_acc[57], r_acc} + {r_prod[57], r_prod[57:0]};
    assign w_vr   = rnd_q24({{7{w_vsum[58]}}, w_vsum});
    assign w_val  = sat32({{22{w_vr[41]}}, w_vr});

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_no_job) begin
                    n_state = ST_TB_HI;
                end
            end
            ST_TB_HI:    n_state = ST_TB_LO;
            ST_TB_LO:    n_state = ST_TS_HI;
            ST_TS_HI:    n_state = ST_TS_LO;
            ST_TS_LO:    n_state = ST_TACC_HI;
            ST_TACC_HI:  n_state = ST_TACC_LO;
            ST_TACC_LO:  n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_LD_BASE;
            ST_LD_BASE:  n_state = ST_FLUX;
            ST_FLUX:     n_state = ST_ACC_BASE;
            ST_ACC_BASE: n_state = ST_UPDATE;
            ST_UPDATE:   n_state = ST_WAIT;
            ST_WAIT:     n_state = ST_BLEND;
            ST_BLEND: begin
                if (w_oload) begin
                    n_state = (!r_job && r_two) ? ST_DIFF : ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_oload    = (r_state == ST_BLEND) && (!r_out_valid || !i_out_stall);
        w_finish   = w_oload && !(!r_job && r_two);
    end

    // Control state, configuration and the held grid cells.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_vel       <= VELOCITY_RESET;
            r_ratio     <= '0;
            r_bw        <= Q24_ONE;
            r_tstep     <= '0;
            r_tnow      <= '0;
            r_tbase     <= '0;
            r_prev_v    <= '0;
            r_prev_b    <= '0;
            r_first_v   <= '0;
            r_first_b   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_VELOCITY:     r_vel   <= $signed(i_cfg_wdata[31:0]);
                    CFG_STEP_RATIO:   r_ratio <= i_cfg_wdata[31:0];
                    CFG_BLEND_WEIGHT: r_bw    <= i_cfg_wdata[WEIGHT_W-1:0];
                    CFG_TIME_STEP:    r_tstep <= i_cfg_wdata[TIME_W-1:0];
                    CFG_TIME_NOW:     r_tnow  <= i_cfg_wdata[TIME_W-1:0];
                    CFG_BASE_TIME:    r_tbase <= i_cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_cnt <= w_last_eff ? '0 : CW'(r_cnt + 1'b1);
                if (r_cnt == '0) begin
                    r_first_v <= i_cell_value;
                    r_first_b <= i_base_value;
                end
                if (w_no_job) begin
                    r_prev_v <= i_cell_value;
                    r_prev_b <= i_base_value;
                end
            end
            // The held cell moves on only after its last use by this beat.
            if (w_finish) begin
                r_prev_v <= r_u;
                r_prev_b <= r_b;
            end
            if (w_oload) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_u    <= i_cell_value;
                    r_b    <= i_base_value;
                    r_k    <= r_cnt;
                    r_two  <= (r_cnt != '0) && w_last_eff;
                    r_job  <= 1'b0;
                    r_tsum <= w_tsum_full[TIME_W] ? '1 : w_tsum_full[TIME_W-1:0];
                end
            end
            ST_TB_HI: begin
                r_ma <= $signed({8'd0, w_wb});
                r_mb <= $signed({9'd0, r_tbase[47:24]});
            end
            ST_TB_LO: begin
                r_ma <= $signed({8'd0, w_wb});
                r_mb <= $signed({9'd0, r_tbase[23:0]});
            end
            ST_TS_HI: begin
                r_tacc <= {r_prod[49:0], 24'd0};
                r_ma   <= $signed({8'd0, w_a});
                r_mb   <= $signed({9'd0, r_tsum[47:24]});
            end
            ST_TS_LO: begin
                r_tacc <= r_tacc + {24'd0, r_prod[49:0]};
                r_ma   <= $signed({8'd0, w_a});
                r_mb   <= $signed({9'd0, r_tsum[23:0]});
            end
            ST_TACC_HI: begin
                r_tacc <= r_tacc + {r_prod[49:0], 24'd0};
            end
            ST_TACC_LO: begin
                r_tacc <= r_tacc + {24'd0, r_prod[49:0]};
            end
            ST_DIFF: begin
                r_time <= w_tround[71:24];
                r_ma   <= {r_vel[31], r_vel};
                r_mb   <= w_d;
            end
            ST_LD_BASE: begin
                r_ma <= $signed({8'd0, w_wb});
                r_mb <= {w_base[31], w_base};
            end
            ST_FLUX: begin
                r_ma <= $signed({1'b0, r_ratio});
                r_mb <= {w_fd[31], w_fd};
            end
            ST_ACC_BASE: begin
                r_acc <= $signed(r_prod[57:0]);
            end
            ST_UPDATE: begin
                r_ma <= $signed({8'd0, w_a});
                r_mb <= {w_nv[31], w_nv};
            end
            ST_WAIT: ;
            ST_BLEND: begin
                if (w_oload) begin
                    r_o_idx  <= CELL_INDEX_W'(w_idx);
                    r_o_val  <= w_val;
                    r_o_time <= r_time;
                    r_o_last <= w_rlast;
                    r_job    <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_index  = r_o_idx;
    assign o_new_value   = r_o_val;
    assign o_new_time    = r_o_time;
    assign o_last_result = r_o_last;

`ifndef ASSERT_OFF
    // The grid position never runs past MAX_CELLS - 1.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_POS)
        else $error("grid position out of range");

    // A result is never written over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_oload |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // A closing beat always restarts the grid position at zero.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_eff) |=> (r_cnt == '0))
        else $error("grid position not restarted after the last cell");

    // The second result of a beat only exists when the beat asked for two.
    a_second_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_oload && r_job) |-> r_two)
        else $error("unexpected second result");
`endif

endmodule

`default_nettype wire
